[hw/rtl/msbm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msbm_pkg: shared types and constants for the multi-stack block mover
// Sizes of the stack store, operation and status codes, item layouts.
// ----------------------------------------------------------------------------
package msbm_pkg;

  localparam int NUM_STACKS  = 16;
  localparam int STACK_DEPTH = 64;
  localparam int ITEM_BITS   = 8;
  localparam int MAX_RESULTS = 16;

  localparam int SIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int PTR_W  = $clog2(STACK_DEPTH);
  localparam int HGT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_STACKS * STACK_DEPTH);
  localparam int CNT_W  = 7;
  localparam int SUM_W  = ((HGT_W > CNT_W) ? HGT_W : CNT_W) + 1;
  localparam int NREP   = (NUM_STACKS < MAX_RESULTS) ? NUM_STACKS : MAX_RESULTS;

  // Operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_PUSH   = 2'd1;
  localparam logic [1:0] OP_MOVE   = 2'd2;
  localparam logic [1:0] OP_REPORT = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  typedef logic [ITEM_BITS-1:0] item_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       item_value;
    logic [CNT_W-1:0] move_count;
    logic [3:0]       source_stack;
    logic [3:0]       dest_stack;
  } msbm_in_t;

  typedef struct packed {
    logic [3:0] stack_number;
    logic [7:0] top_value;
    logic       stack_empty;
    logic [1:0] status;
    logic       last;
  } msbm_out_t;

  // Fold a stack index into range
  function automatic logic [SIDX_W-1:0] pick_stack(input logic [3:0] v);
    return SIDX_W'(v % NUM_STACKS);
  endfunction

  // Store address of one entry of one stack
  function automatic addr_t stack_addr(input logic [SIDX_W-1:0] idx,
                                       input logic [PTR_W-1:0] ptr);
    return addr_t'(addr_t'(idx) * addr_t'(STACK_DEPTH)) + addr_t'(ptr);
  endfunction

endpackage
`default_nettype wire

[hw/rtl/multi_stack_block_mover.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multi_stack_block_mover: bounded byte stacks with push, move and report
// A sequencer drives one item store port pair to push, copy and read tops.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------
//  input    | start, busy           | in_item   (msbm_in_t)
//  result   | out_valid (strobe)    | out_item  (msbm_out_t)
//  config   | cfg_valid, cfg_ready  | cfg_data  (move mode)
//
// The copy loop moves one item per cycle through the store's single read
// and write port.
// Reset (rst_n low, synchronous) empties all stacks and selects mode 0.
// Results are one-cycle strobes; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module multi_stack_block_mover
  import msbm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire msbm_in_t  in_item,
  output logic           out_valid,
  output msbm_out_t      out_item,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_HD      = 4'd1;
  localparam logic [3:0] S_HS      = 4'd2;
  localparam logic [3:0] S_CHECK   = 4'd3;
  localparam logic [3:0] S_COPY    = 4'd4;
  localparam logic [3:0] S_UPD_SRC = 4'd5;
  localparam logic [3:0] S_UPD_DST = 4'd6;
  localparam logic [3:0] S_DESC    = 4'd7;
  localparam logic [3:0] S_EMIT    = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic              mode_r, mode_nxt;
  logic [1:0]        op_r, op_nxt;
  item_t             val_r, val_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SIDX_W-1:0] src_r, src_nxt;
  logic [SIDX_W-1:0] dst_r, dst_nxt;
  logic [HGT_W-1:0]  hd_r, hd_nxt;
  logic [HGT_W-1:0]  hs_r, hs_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic              pend_r, pend_nxt;
  addr_t             pend_wa_r, pend_wa_nxt;
  logic [SIDX_W-1:0] desc_idx_r, desc_idx_nxt;
  logic [HGT_W-1:0]  desc_h_r, desc_h_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  msbm_out_t         out_item_r, out_item_nxt;

  logic [HGT_W-1:0]  hgt_r [NUM_STACKS];
  logic [SIDX_W-1:0] h_sel;
  logic [HGT_W-1:0]  h_rd;
  logic              hgt_we, hgt_clr;
  logic [SIDX_W-1:0] hgt_wi;
  logic [HGT_W-1:0]  hgt_wd;

  logic              mem_we, mem_re;
  addr_t             mem_wa, mem_ra;
  item_t             mem_wd, mem_rd;

  logic [SUM_W-1:0]  dst_sum;
  logic              rep_last;

  msbm_store u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Height table read select
  always_comb begin
    unique case (state_r)
      S_HS:    h_sel = src_r;
      S_DESC:  h_sel = desc_idx_r;
      default: h_sel = dst_r;
    endcase
  end
  assign h_rd = hgt_r[h_sel];

  assign dst_sum  = SUM_W'(hd_r) + SUM_W'(cnt_r);
  assign rep_last = (desc_idx_r == SIDX_W'(NREP - 1));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    hd_nxt        = hd_r;
    hs_nxt        = hs_r;
    rem_nxt       = rem_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    pend_nxt      = 1'b0;
    pend_wa_nxt   = pend_wa_r;
    desc_idx_nxt  = desc_idx_r;
    desc_h_nxt    = desc_h_r;
    status_nxt    = status_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    hgt_we        = 1'b0;
    hgt_clr       = 1'b0;
    hgt_wi        = dst_r;
    hgt_wd        = hd_r;
    mem_we        = pend_r;
    mem_wa        = pend_wa_r;
    mem_wd        = mem_rd;
    mem_re        = 1'b0;
    mem_ra        = stack_addr(src_r, rd_ptr_r);

    if (cfg_valid && cfg_ready) begin
      mode_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt       = in_item.op;
          val_nxt      = item_t'(in_item.item_value);
          cnt_nxt      = in_item.move_count;
          src_nxt      = pick_stack(in_item.source_stack);
          dst_nxt      = pick_stack(in_item.dest_stack);
          status_nxt   = ST_OK;
          desc_idx_nxt = '0;
          unique case (in_item.op)
            OP_CLEAR: begin
              hgt_clr   = 1'b1;
              state_nxt = S_DESC;
            end
            OP_PUSH:   state_nxt = S_HD;
            OP_MOVE:   state_nxt = S_HD;
            OP_REPORT: state_nxt = S_DESC;
          endcase
        end
      end

      // Capture destination height
      S_HD: begin
        hd_nxt    = h_rd;
        state_nxt = (op_r == OP_MOVE) ? S_HS : S_CHECK;
      end

      // Capture source height
      S_HS: begin
        hs_nxt    = h_rd;
        state_nxt = S_CHECK;
      end

      // Decide status; write a push or set up the copy loop
      S_CHECK: begin
        desc_idx_nxt = dst_r;
        state_nxt    = S_DESC;
        if (op_r == OP_PUSH) begin
          mem_we = 1'b0;
          if (hd_r >= HGT_W'(STACK_DEPTH)) begin
            status_nxt = ST_OVER;
          end else begin
            mem_we = 1'b1;
            mem_wa = stack_addr(dst_r, PTR_W'(hd_r));
            mem_wd = val_r;
            hgt_we = 1'b1;
            hgt_wi = dst_r;
            hgt_wd = HGT_W'(hd_r + 1'b1);
          end
        end else begin
          if (SUM_W'(cnt_r) > SUM_W'(hs_r)) begin
            status_nxt = ST_UNDER;
          end else if (src_r == dst_r || cnt_r == '0) begin
            status_nxt = ST_OK;
          end else if (dst_sum > SUM_W'(STACK_DEPTH)) begin
            status_nxt = ST_OVER;
          end else begin
            rem_nxt    = cnt_r;
            wr_ptr_nxt = PTR_W'(hd_r);
            rd_ptr_nxt = mode_r ? PTR_W'(hs_r - HGT_W'(cnt_r)) : PTR_W'(hs_r - 1'b1);
            state_nxt  = S_COPY;
          end
        end
      end

      // Copy one item per cycle; each write lands in the cycle after its read
      S_COPY: begin
        if (rem_r != '0) begin
          mem_re      = 1'b1;
          mem_ra      = stack_addr(src_r, rd_ptr_r);
          rd_ptr_nxt  = mode_r ? PTR_W'(rd_ptr_r + 1'b1) : PTR_W'(rd_ptr_r - 1'b1);
          rem_nxt     = CNT_W'(rem_r - 1'b1);
          pend_nxt    = 1'b1;
          pend_wa_nxt = stack_addr(dst_r, wr_ptr_r);
          wr_ptr_nxt  = PTR_W'(wr_ptr_r + 1'b1);
        end else begin
          state_nxt = S_UPD_SRC;
        end
      end

      S_UPD_SRC: begin
        hgt_we    = 1'b1;
        hgt_wi    = src_r;
        hgt_wd    = HGT_W'(hs_r - HGT_W'(cnt_r));
        state_nxt = S_UPD_DST;
      end

      S_UPD_DST: begin
        hgt_we    = 1'b1;
        hgt_wi    = dst_r;
        hgt_wd    = HGT_W'(dst_sum);
        state_nxt = S_DESC;
      end

      // Read the top entry of the described stack
      S_DESC: begin
        desc_h_nxt = h_rd;
        mem_re     = 1'b1;
        mem_ra     = stack_addr(desc_idx_r, PTR_W'(h_rd - 1'b1));
        state_nxt  = S_EMIT;
      end

      // Drive one result; advance through the stacks on a report
      S_EMIT: begin
        out_valid_nxt             = 1'b1;
        out_item_nxt.stack_number = 4'(desc_idx_r);
        out_item_nxt.top_value    = (desc_h_r == '0) ? 8'd0 : 8'(mem_rd);
        out_item_nxt.stack_empty  = (desc_h_r == '0);
        out_item_nxt.status       = status_r;
        out_item_nxt.last         = (op_r != OP_REPORT) || rep_last;
        if (op_r == OP_REPORT && !rep_last) begin
          desc_idx_nxt = SIDX_W'(desc_idx_r + 1'b1);
          state_nxt    = S_DESC;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stack heights
  always_ff @(posedge clk) begin
    if (!rst_n || hgt_clr) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        hgt_r[i] <= '0;
      end
    end else if (hgt_we) begin
      hgt_r[hgt_wi] <= hgt_wd;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    cnt_r      <= cnt_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    hd_r       <= hd_nxt;
    hs_r       <= hs_nxt;
    rem_r      <= rem_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    pend_wa_r  <= pend_wa_nxt;
    desc_idx_r <= desc_idx_nxt;
    desc_h_r   <= desc_h_nxt;
    status_r   <= status_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
`default_nettype wire

[hw/rtl/msbm_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msbm_store: item store for all stacks
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module msbm_store
  import msbm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  wr_en,
  input  wire addr_t wr_addr,
  input  wire item_t wr_data,
  input  wire logic  rd_en,
  input  wire addr_t rd_addr,
  output item_t      rd_data
);

  item_t mem [NUM_STACKS*STACK_DEPTH];
  item_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[bench/msbm_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msbm_checker: scoreboard for the multi-stack block mover
// Watches the command, result and mode-write channels. Keeps a shadow copy
// of every stack and the move mode, works out the result items of each
// accepted command and compares each result strobe field by field with the
// oldest one still owed.
// ----------------------------------------------------------------------------
module msbm_checker
  import msbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  msbm_in_t  in_item,
  input  logic      out_valid,
  input  msbm_out_t out_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_data,
  output int        fail_count,
  output int        owed_count,
  output int        checked_count
);

  localparam int MAX_PRINTS = 40;

  // Shadow stacks and mode
  logic [ITEM_BITS-1:0] shadow_mem [NUM_STACKS][STACK_DEPTH];
  int unsigned          shadow_hgt [NUM_STACKS];
  logic                 shadow_mode;
  msbm_out_t            owed_results [$];

  initial begin
    fail_count    = 0;
    checked_count = 0;
  end

  assign owed_count = owed_results.size();

  // Print one mismatch line and count it
  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTS) begin
      $display("%0t ns: result %0d: %s", $time, checked_count, msg);
    end
    fail_count++;
  endtask

  // Describe one stack as it stands now
  function automatic msbm_out_t describe_stack(input int unsigned s, input logic [1:0] st,
                                               input logic fin);
    msbm_out_t r;
    r.stack_number = 4'(s);
    r.top_value    = (shadow_hgt[s] != 0) ? 8'(shadow_mem[s][shadow_hgt[s] - 1]) : 8'h00;
    r.stack_empty  = (shadow_hgt[s] == 0);
    r.status       = st;
    r.last         = fin;
    return r;
  endfunction

  // Apply one command to the shadow stacks and queue the results it owes
  task automatic apply_command(input msbm_in_t cmd);
    int unsigned src;
    int unsigned dst;
    int unsigned cnt;
    int unsigned hs;
    int unsigned hd;
    int unsigned from;
    logic [1:0]  st;
    src = int'(cmd.source_stack) % NUM_STACKS;
    dst = int'(cmd.dest_stack) % NUM_STACKS;
    cnt = int'(cmd.move_count);
    st  = ST_OK;
    case (cmd.op)
      OP_CLEAR: begin
        for (int s = 0; s < NUM_STACKS; s++) shadow_hgt[s] = 0;
        owed_results.push_back(describe_stack(0, ST_OK, 1'b1));
      end
      OP_PUSH: begin
        hd = shadow_hgt[dst];
        if (hd >= STACK_DEPTH) begin
          st = ST_OVER;
        end else begin
          shadow_mem[dst][hd] = ITEM_BITS'(cmd.item_value);
          shadow_hgt[dst]     = hd + 1;
        end
        owed_results.push_back(describe_stack(dst, st, 1'b1));
      end
      OP_MOVE: begin
        hs = shadow_hgt[src];
        hd = shadow_hgt[dst];
        // Underflow wins over everything; a move onto itself changes nothing
        if (cnt > hs) begin
          st = ST_UNDER;
        end else if (src != dst) begin
          if (hd + cnt > STACK_DEPTH) begin
            st = ST_OVER;
          end else begin
            for (int unsigned i = 0; i < cnt; i++) begin
              from = shadow_mode ? (hs - cnt + i) : (hs - 1 - i);
              shadow_mem[dst][hd + i] = shadow_mem[src][from];
            end
            shadow_hgt[src] = hs - cnt;
            shadow_hgt[dst] = hd + cnt;
          end
        end
        owed_results.push_back(describe_stack(dst, st, 1'b1));
      end
      default: begin
        for (int k = 0; k < NREP; k++) begin
          owed_results.push_back(describe_stack(k, ST_OK, k == NREP - 1));
        end
      end
    endcase
  endtask

  // Compare one result strobe with the oldest owed result
  task automatic check_result(input msbm_out_t got);
    msbm_out_t want;
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
    end else begin
      want = owed_results.pop_front();
      if (got.stack_number !== want.stack_number)
        report_mismatch($sformatf("stack_number %0d, expected %0d",
                                  got.stack_number, want.stack_number));
      if (got.top_value !== want.top_value)
        report_mismatch($sformatf("top_value %0d, expected %0d",
                                  got.top_value, want.top_value));
      if (got.stack_empty !== want.stack_empty)
        report_mismatch($sformatf("stack_empty %0b, expected %0b",
                                  got.stack_empty, want.stack_empty));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    end
    checked_count++;
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_STACKS; s++) shadow_hgt[s] = 0;
      shadow_mode = 1'b0;
      owed_results.delete();
    end else begin
      if (out_valid === 1'b1) check_result(out_item);
      if (cfg_valid && cfg_ready) shadow_mode = cfg_data;
      if (start && busy === 1'b0) apply_command(in_item);
    end
  end

endmodule

[bench/multi_stack_block_mover_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_stack_block_mover_tb: top of the multi-stack block mover bench
// Drives a short directed list of commands, then random phases that spread
// items over all stacks, crowd a pair of stacks, or pack one stack until it
// overflows, switching the move mode between phases while the block is idle.
// Commands go out in bursts with random gaps; the checker scores results.
// ----------------------------------------------------------------------------
module multi_stack_block_mover_tb;
  import msbm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 100;
  localparam int NUM_PHASES     = 4;

  typedef enum int {SPREAD, PAIR, PACK} phase_kind_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  msbm_in_t  in_item;
  logic      out_valid;
  msbm_out_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  int        fail_count;
  int        owed_count;
  int        checked_count;
  int        burst_left;
  int        sent_count;
  int        idle_cycles;

  multi_stack_block_mover i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  msbm_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .owed_count    (owed_count),
    .checked_count (checked_count)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: end the run when nothing moves for too long
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic msbm_in_t pack_command(input logic [1:0] op, input logic [7:0] value,
                                            input int count, input int src, input int dst);
    msbm_in_t c;
    c.op           = op;
    c.item_value   = value;
    c.move_count   = CNT_W'(count);
    c.source_stack = 4'(src);
    c.dest_stack   = 4'(dst);
    return c;
  endfunction

  // Pick a stack index according to the phase focus
  function automatic int pick_index(input phase_kind_t kind, input int base);
    case (kind)
      PAIR:    return base + $urandom_range(0, 1);
      PACK:    return ($urandom_range(0, 9) != 0) ? base : $urandom_range(0, 15);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  // Build one random command, weighted by phase
  function automatic msbm_in_t random_command(input phase_kind_t kind, input int base);
    int          roll;
    int          count;
    logic [1:0]  op;
    roll  = $urandom_range(0, 99);
    count = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(0, 64);
    case (kind)
      SPREAD:  op = (roll < 3) ? OP_CLEAR : (roll < 50) ? OP_PUSH :
                    (roll < 88) ? OP_MOVE : OP_REPORT;
      PAIR:    op = (roll < 2) ? OP_CLEAR : (roll < 55) ? OP_PUSH :
                    (roll < 92) ? OP_MOVE : OP_REPORT;
      default: op = (roll < 80) ? OP_PUSH : (roll < 95) ? OP_MOVE : OP_REPORT;
    endcase
    return pack_command(op, 8'($urandom), count, pick_index(kind, base),
                        pick_index(kind, base));
  endfunction

  // Send one item: open a gap when a burst runs out, then wait for acceptance
  task automatic send_command(input msbm_in_t cmd);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    start   <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy !== 1'b0);
    burst_left--;
    sent_count++;
  endtask

  // Drop start and hold until every owed result is in and the block is idle
  task automatic wait_quiet();
    start <= 1'b0;
    burst_left = 0;
    while (owed_count != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_move_mode(input logic mode);
    wait_quiet();
    cfg_data  <= mode;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    phase_kind_t kind;
    int          base;
    int          length;
    start      = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    rst_n      = 1'b0;
    burst_left = 0;
    sent_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, mode 0: empty report, extremes, refusals, reversing move
    write_move_mode(1'b0);
    send_command(pack_command(OP_REPORT, 8'h00, 0, 0, 0));
    send_command(pack_command(OP_PUSH, 8'h00, 0, 0, 0));
    send_command(pack_command(OP_PUSH, 8'hFF, 0, 15, 15));
    send_command(pack_command(OP_PUSH, 8'hA5, 0, 0, 0));
    send_command(pack_command(OP_PUSH, 8'h5A, 0, 0, 0));
    send_command(pack_command(OP_PUSH, 8'h3C, 0, 0, 0));
    send_command(pack_command(OP_MOVE, 8'h00, 5, 0, 1));
    send_command(pack_command(OP_MOVE, 8'h00, 2, 0, 0));
    send_command(pack_command(OP_MOVE, 8'h00, 0, 3, 4));
    send_command(pack_command(OP_MOVE, 8'h00, 3, 0, 1));
    send_command(pack_command(OP_REPORT, 8'h00, 0, 0, 0));
    send_command(pack_command(OP_CLEAR, 8'h00, 0, 0, 0));

    // Directed, mode 1: order-keeping move, full-depth count underflow
    write_move_mode(1'b1);
    send_command(pack_command(OP_PUSH, 8'h01, 0, 0, 2));
    send_command(pack_command(OP_PUSH, 8'h02, 0, 0, 2));
    send_command(pack_command(OP_PUSH, 8'h03, 0, 0, 2));
    send_command(pack_command(OP_MOVE, 8'h00, 3, 2, 5));
    send_command(pack_command(OP_REPORT, 8'h00, 0, 0, 0));
    send_command(pack_command(OP_MOVE, 8'h00, 64, 5, 6));
    send_command(pack_command(OP_MOVE, 8'h00, 0, 15, 15));

    // Random phases, alternating move mode
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_move_mode(p % 2 == 0);
      case (p)
        0:       kind = SPREAD;
        2:       kind = PAIR;
        default: kind = PACK;
      endcase
      base   = (kind == PAIR) ? $urandom_range(0, 14) : $urandom_range(0, 15);
      length = (kind == PACK) ? 100 : 85;
      for (int n = 0; n < length; n++) send_command(random_command(kind, base));
    end

    // Drain, then give the verdict
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d commands sent, %0d results checked, %0d mismatches",
             sent_count, checked_count, fail_count);
    $display("covered clears, pushes, reports and moves in both modes, with refusals");
    if (fail_count == 0 && owed_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
